@@ hdl/dlts_pkg.sv @@
// Shared types, constants and helpers for the delta-list task scheduler.
`default_nettype none
package dlts_pkg;

    // Default size of the task table.
    localparam int MAX_TASKS_DEF = 32;

    // Stored delays are 18-bit signed and saturate at the ends of that range.
    localparam int DELTA_W   = 18;
    localparam int DELTA_MAX = 131071;
    localparam int DELTA_MIN = -131072;

    // Width of the running remainder during an ordered scan. A remainder can
    // collect one stored delay per visited entry, which stays well inside this.
    localparam int REM_W = 26;

    // Most tasks that one dispatch request may report.
    localparam int DISP_CAP = 32;
    localparam int DISP_W   = $clog2(DISP_CAP + 1);

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_ADD  = 2'd1,
        REQ_DEL  = 2'd2,
        REQ_DISP = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NO_HANDLE = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  task_handle;
        logic [15:0] first_delay;
        logic [15:0] repeat_period;
        logic [15:0] target_id;
    } req_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] assigned_id;
        logic        run_valid;
        logic [7:0]  run_handle;
        logic        last;
    } rsp_word_t;

    // One row of the task table.
    typedef struct packed {
        logic [7:0]         handle;
        logic [DELTA_W-1:0] delta;
        logic [15:0]        period;
        logic [15:0]        ident;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TICK_RD,
        S_TICK_WR,
        S_ADD_RD,
        S_ADD_EV,
        S_ADD_FIX,
        S_ADD_SH_RD,
        S_ADD_SH_WR,
        S_ADD_NXT,
        S_ADD_NEW,
        S_DEL_RD,
        S_DEL_EV,
        S_RM_RD,
        S_RM_WR,
        S_DISP_RD,
        S_DISP_EV,
        S_RI_RD,
        S_RI_EV,
        S_RI_HEAD,
        S_RI_FIX,
        S_EMIT
    } state_t;

    // Sign-extend a stored delay to the remainder width.
    function automatic logic [REM_W-1:0] sext_delta(input logic [DELTA_W-1:0] d);
        return {{(REM_W - DELTA_W){d[DELTA_W-1]}}, d};
    endfunction

endpackage
`default_nettype wire

@@ hdl/delta_list_task_scheduler.sv @@
// Top level of the delta-list task scheduler: sequencer, table and shared ALU.
//
//  channel | direction | handshake              | word
//  req     | in        | req_valid / req_ready  | dlts_pkg::req_word_t
//  rsp     | out       | rsp_valid / rsp_ready  | dlts_pkg::rsp_word_t
//
// Every table access goes through one memory port pair with a registered read,
// and every delay add, subtract or compare through one shared ALU, so a request
// walks the table one entry at a time: a tick reads and rewrites the head entry, an
// add scans past earlier entries and then shifts later ones, a delete scans and
// moves the later entries up. A dispatch moves entries for each task it reports.
// req_ready is high only while the sequencer is idle; a stalled rsp holds the
// sequencer in its output step. Reset clears the control state and the count.
`default_nettype none
module delta_list_task_scheduler #(
    parameter int MAX_TASKS = dlts_pkg::MAX_TASKS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  dlts_pkg::req_word_t   req,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output dlts_pkg::rsp_word_t   rsp
);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int AW = $clog2(MAX_TASKS);
    localparam int RW = dlts_pkg::REM_W;
    localparam int DW = dlts_pkg::DELTA_W;
    localparam int NW = dlts_pkg::DISP_W;

    dlts_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       sh_reg, sh_next;
    logic [RW-1:0]       rem_reg, rem_next;
    logic [NW-1:0]       ndisp_reg, ndisp_next;
    logic                pend_reg, pend_next;
    logic                fold_reg, fold_next;
    logic                back_reg, back_next;
    logic [15:0]         ident_reg, ident_next;
    dlts_pkg::req_word_t cur_reg, cur_next;
    dlts_pkg::entry_t    hold_reg, hold_next;
    dlts_pkg::entry_t    nxt_reg, nxt_next;
    dlts_pkg::rsp_word_t res_reg, res_next;
    dlts_pkg::rsp_word_t rsp_reg;
    logic                rsp_valid_reg, rsp_valid_next;

    logic [AW-1:0]       rd_addr;
    dlts_pkg::entry_t    rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    dlts_pkg::entry_t    wr_data;

    logic [RW-1:0]       alu_a, alu_b;
    logic                alu_sub;
    logic [RW:0]         alu_sum;
    logic [DW-1:0]       alu_sat;
    logic                alu_gt, alu_eq;

    logic                accept, load, goes, due, match;
    logic [15:0]         per_cmp;
    logic [CW-1:0]       idx_p1, idx_m1, sh_m1;
    dlts_pkg::rsp_word_t res_tail;

    dlts_table #(
        .DEPTH (MAX_TASKS),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    dlts_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum),
        .sat (alu_sat),
        .gt  (alu_gt),
        .eq  (alu_eq)
    );

    // Decisions shared by the sequencer blocks.
    always_comb
    begin
        accept  = req_valid && req_ready;
        load    = (state_reg == dlts_pkg::S_EMIT) && (!rsp_valid_reg || rsp_ready);
        idx_p1  = idx_reg + 1'b1;
        idx_m1  = idx_reg - 1'b1;
        sh_m1   = sh_reg - 1'b1;
        per_cmp = (state_reg == dlts_pkg::S_ADD_EV) ? cur_reg.repeat_period
                                                    : hold_reg.period;
        goes    = alu_gt || (alu_eq && (per_cmp <= rd_data.period));
        due     = rd_data.delta[DW-1] || (rd_data.delta == '0);
        match   = (rd_data.ident == cur_reg.target_id);
        // Closing word of a dispatch: the held task, or nothing due.
        res_tail.status      = dlts_pkg::ST_OK;
        res_tail.assigned_id = '0;
        res_tail.run_valid   = pend_reg;
        res_tail.run_handle  = pend_reg ? hold_reg.handle : 8'd0;
        res_tail.last        = 1'b1;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dlts_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (dlts_pkg::req_kind_t'(req.req_type))
                        dlts_pkg::REQ_TICK:
                            state_next = (count_reg == '0) ? dlts_pkg::S_EMIT
                                                           : dlts_pkg::S_TICK_RD;
                        dlts_pkg::REQ_ADD:
                            state_next = (count_reg >= CW'(MAX_TASKS)
                                          || req.task_handle == 8'd0)
                                         ? dlts_pkg::S_EMIT : dlts_pkg::S_ADD_RD;
                        dlts_pkg::REQ_DEL:
                            state_next = dlts_pkg::S_DEL_RD;
                        dlts_pkg::REQ_DISP:
                            state_next = dlts_pkg::S_DISP_RD;
                        default:
                            state_next = dlts_pkg::S_IDLE;
                    endcase
                end
            end
            dlts_pkg::S_TICK_RD:   state_next = dlts_pkg::S_TICK_WR;
            dlts_pkg::S_TICK_WR:   state_next = dlts_pkg::S_EMIT;
            dlts_pkg::S_ADD_RD:
                state_next = (idx_reg == count_reg) ? dlts_pkg::S_ADD_NEW
                                                    : dlts_pkg::S_ADD_EV;
            dlts_pkg::S_ADD_EV:
                state_next = goes ? dlts_pkg::S_ADD_RD : dlts_pkg::S_ADD_FIX;
            dlts_pkg::S_ADD_FIX:   state_next = dlts_pkg::S_ADD_SH_RD;
            dlts_pkg::S_ADD_SH_RD:
                state_next = (sh_reg > idx_p1) ? dlts_pkg::S_ADD_SH_WR
                                               : dlts_pkg::S_ADD_NXT;
            dlts_pkg::S_ADD_SH_WR: state_next = dlts_pkg::S_ADD_SH_RD;
            dlts_pkg::S_ADD_NXT:   state_next = dlts_pkg::S_ADD_NEW;
            dlts_pkg::S_ADD_NEW:   state_next = dlts_pkg::S_EMIT;
            dlts_pkg::S_DEL_RD:
                state_next = (idx_reg == count_reg) ? dlts_pkg::S_EMIT
                                                    : dlts_pkg::S_DEL_EV;
            dlts_pkg::S_DEL_EV:
                state_next = match ? dlts_pkg::S_RM_RD : dlts_pkg::S_DEL_RD;
            dlts_pkg::S_RM_RD:
            begin
                if (idx_p1 < count_reg)
                begin
                    state_next = dlts_pkg::S_RM_WR;
                end
                else if (cur_reg.req_type == dlts_pkg::REQ_DEL)
                begin
                    state_next = dlts_pkg::S_EMIT;
                end
                else
                begin
                    state_next = dlts_pkg::S_DISP_RD;
                end
            end
            dlts_pkg::S_RM_WR:     state_next = dlts_pkg::S_RM_RD;
            dlts_pkg::S_DISP_RD:
                state_next = (count_reg != '0 && ndisp_reg < NW'(dlts_pkg::DISP_CAP))
                             ? dlts_pkg::S_DISP_EV : dlts_pkg::S_EMIT;
            dlts_pkg::S_DISP_EV:
            begin
                if (!due || pend_reg)
                begin
                    state_next = dlts_pkg::S_EMIT;
                end
                else if (rd_data.period != 16'd0)
                begin
                    state_next = dlts_pkg::S_RI_RD;
                end
                else
                begin
                    state_next = dlts_pkg::S_RM_RD;
                end
            end
            dlts_pkg::S_RI_RD:
                state_next = (idx_reg < count_reg) ? dlts_pkg::S_RI_EV
                                                   : dlts_pkg::S_RI_HEAD;
            dlts_pkg::S_RI_EV:
                state_next = goes ? dlts_pkg::S_RI_RD : dlts_pkg::S_RI_HEAD;
            dlts_pkg::S_RI_HEAD:
                state_next = (idx_reg < count_reg) ? dlts_pkg::S_RI_FIX
                                                   : dlts_pkg::S_DISP_RD;
            dlts_pkg::S_RI_FIX:    state_next = dlts_pkg::S_DISP_RD;
            dlts_pkg::S_EMIT:
            begin
                if (load)
                begin
                    state_next = back_reg ? dlts_pkg::S_DISP_RD : dlts_pkg::S_IDLE;
                end
            end
            default:               state_next = dlts_pkg::S_IDLE;
        endcase
    end

    // Memory port and ALU operand selection.
    always_comb
    begin
        req_ready = (state_reg == dlts_pkg::S_IDLE);
        rd_addr   = idx_reg[AW-1:0];
        wr_en     = 1'b0;
        wr_addr   = idx_reg[AW-1:0];
        wr_data   = rd_data;
        alu_a     = rem_reg;
        alu_b     = dlts_pkg::sext_delta(rd_data.delta);
        alu_sub   = 1'b1;
        unique case (state_reg)
            dlts_pkg::S_TICK_RD,
            dlts_pkg::S_DISP_RD:
            begin
                rd_addr = '0;
            end
            dlts_pkg::S_TICK_WR:
            begin
                alu_a         = dlts_pkg::sext_delta(rd_data.delta);
                alu_b         = {{(RW - 1){1'b0}}, 1'b1};
                wr_en         = 1'b1;
                wr_addr       = '0;
                wr_data.delta = alu_sat;
            end
            dlts_pkg::S_ADD_FIX:
            begin
                alu_a = dlts_pkg::sext_delta(nxt_reg.delta);
                alu_b = rem_reg;
            end
            dlts_pkg::S_ADD_SH_RD:
            begin
                rd_addr = sh_m1[AW-1:0];
            end
            dlts_pkg::S_ADD_SH_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = sh_reg[AW-1:0];
            end
            dlts_pkg::S_ADD_NXT:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_p1[AW-1:0];
                wr_data = nxt_reg;
            end
            dlts_pkg::S_ADD_NEW:
            begin
                alu_b          = '0;
                alu_sub        = 1'b0;
                wr_en          = 1'b1;
                wr_data.handle = cur_reg.task_handle;
                wr_data.delta  = alu_sat;
                wr_data.period = cur_reg.repeat_period;
                wr_data.ident  = ident_reg;
            end
            dlts_pkg::S_RM_RD:
            begin
                rd_addr = idx_p1[AW-1:0];
            end
            dlts_pkg::S_RM_WR:
            begin
                alu_a   = dlts_pkg::sext_delta(rd_data.delta);
                alu_b   = dlts_pkg::sext_delta(hold_reg.delta);
                alu_sub = 1'b0;
                wr_en   = 1'b1;
                if (fold_reg)
                begin
                    wr_data.delta = alu_sat;
                end
            end
            dlts_pkg::S_RI_EV:
            begin
                wr_en   = goes;
                wr_addr = idx_m1[AW-1:0];
            end
            dlts_pkg::S_RI_HEAD:
            begin
                alu_b         = '0;
                alu_sub       = 1'b0;
                wr_en         = 1'b1;
                wr_addr       = idx_m1[AW-1:0];
                wr_data       = hold_reg;
                wr_data.delta = alu_sat;
            end
            dlts_pkg::S_RI_FIX:
            begin
                alu_a         = dlts_pkg::sext_delta(nxt_reg.delta);
                alu_b         = rem_reg;
                wr_en         = 1'b1;
                wr_data       = nxt_reg;
                wr_data.delta = alu_sat;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Working registers of the sequencer.
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        sh_next    = sh_reg;
        rem_next   = rem_reg;
        ndisp_next = ndisp_reg;
        pend_next  = pend_reg;
        fold_next  = fold_reg;
        back_next  = back_reg;
        ident_next = ident_reg;
        cur_next   = cur_reg;
        hold_next  = hold_reg;
        nxt_next   = nxt_reg;
        res_next   = res_reg;
        unique case (state_reg)
            dlts_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cur_next             = req;
                    idx_next             = '0;
                    rem_next             = {{(RW - 16){1'b0}}, req.first_delay};
                    ndisp_next           = '0;
                    pend_next            = 1'b0;
                    fold_next            = 1'b1;
                    back_next            = 1'b0;
                    res_next.status      = dlts_pkg::ST_OK;
                    res_next.assigned_id = '0;
                    res_next.run_valid   = 1'b0;
                    res_next.run_handle  = '0;
                    res_next.last        = 1'b1;
                    if (req.req_type == dlts_pkg::REQ_ADD)
                    begin
                        if (count_reg >= CW'(MAX_TASKS))
                        begin
                            res_next.status = dlts_pkg::ST_FULL;
                        end
                        else if (req.task_handle == 8'd0)
                        begin
                            res_next.status = dlts_pkg::ST_NO_HANDLE;
                        end
                    end
                end
            end
            dlts_pkg::S_ADD_EV:
            begin
                if (goes)
                begin
                    rem_next = alu_sum[RW-1:0];
                    idx_next = idx_p1;
                end
                else
                begin
                    nxt_next = rd_data;
                end
            end
            dlts_pkg::S_ADD_FIX:
            begin
                nxt_next.delta = alu_sat;
                sh_next        = count_reg;
            end
            dlts_pkg::S_ADD_SH_WR:
            begin
                sh_next = sh_m1;
            end
            dlts_pkg::S_ADD_NEW:
            begin
                count_next           = count_reg + 1'b1;
                ident_next           = ident_reg + 16'd1;
                res_next.assigned_id = ident_reg;
            end
            dlts_pkg::S_DEL_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    res_next.status = dlts_pkg::ST_NOT_FOUND;
                end
            end
            dlts_pkg::S_DEL_EV:
            begin
                if (match)
                begin
                    hold_next = rd_data;
                end
                else
                begin
                    idx_next = idx_p1;
                end
            end
            dlts_pkg::S_RM_RD:
            begin
                if (!(idx_p1 < count_reg))
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            dlts_pkg::S_RM_WR:
            begin
                fold_next = 1'b0;
                idx_next  = idx_p1;
            end
            dlts_pkg::S_DISP_RD:
            begin
                if (!(count_reg != '0 && ndisp_reg < NW'(dlts_pkg::DISP_CAP)))
                begin
                    res_next  = res_tail;
                    back_next = 1'b0;
                end
            end
            dlts_pkg::S_DISP_EV:
            begin
                if (!due)
                begin
                    res_next  = res_tail;
                    back_next = 1'b0;
                end
                else if (pend_reg)
                begin
                    // Report the held task; another due task follows it.
                    res_next      = res_tail;
                    res_next.last = 1'b0;
                    pend_next     = 1'b0;
                    back_next     = 1'b1;
                end
                else
                begin
                    hold_next  = rd_data;
                    ndisp_next = ndisp_reg + 1'b1;
                    pend_next  = 1'b1;
                    if (rd_data.period != 16'd0)
                    begin
                        rem_next = {{(RW - 16){1'b0}}, rd_data.period};
                        idx_next = {{(CW - 1){1'b0}}, 1'b1};
                    end
                    else
                    begin
                        idx_next  = '0;
                        fold_next = 1'b1;
                    end
                end
            end
            dlts_pkg::S_RI_EV:
            begin
                if (goes)
                begin
                    rem_next = alu_sum[RW-1:0];
                    idx_next = idx_p1;
                end
                else
                begin
                    nxt_next = rd_data;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // Output register: holds a word until the consumer takes it.
    always_comb
    begin
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dlts_pkg::S_IDLE;
            count_reg     <= '0;
            ident_reg     <= 16'd1;
            ndisp_reg     <= '0;
            pend_reg      <= 1'b0;
            fold_reg      <= 1'b0;
            back_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ident_reg     <= ident_next;
            ndisp_reg     <= ndisp_next;
            pend_reg      <= pend_next;
            fold_reg      <= fold_next;
            back_reg      <= back_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        cur_reg  <= cur_next;
        hold_reg <= hold_next;
        nxt_reg  <= nxt_next;
        res_reg  <= res_next;
        if (load)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // The table never holds more tasks than it has rows.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_TASKS))
        else $error("task count exceeds table size");

    // A dispatch never reports more than its cap.
    a_disp_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ndisp_reg <= NW'(dlts_pkg::DISP_CAP))
        else $error("dispatch count exceeds cap");

    // An accepted request always starts work.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != dlts_pkg::S_IDLE))
        else $error("accepted request left sequencer idle");

    // A loaded word is presented on the next cycle.
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> rsp_valid_reg)
        else $error("loaded response not presented");
`endif
endmodule
`default_nettype wire

@@ hdl/dlts_alu.sv @@
// Shared add/subtract unit with compare flags and 18-bit saturation.
`default_nettype none
module dlts_alu (
    input  wire logic [dlts_pkg::REM_W-1:0]   a,
    input  wire logic [dlts_pkg::REM_W-1:0]   b,
    input  wire logic                         sub,
    output logic      [dlts_pkg::REM_W:0]     sum,
    output logic      [dlts_pkg::DELTA_W-1:0] sat,
    output logic                              gt,
    output logic                              eq
);
    localparam int RW = dlts_pkg::REM_W;
    localparam int DW = dlts_pkg::DELTA_W;
    localparam logic signed [RW:0] SAT_HI = (RW + 1)'(dlts_pkg::DELTA_MAX);
    localparam logic signed [RW:0] SAT_LO = (RW + 1)'(dlts_pkg::DELTA_MIN);

    logic [RW:0] a_x;
    logic [RW:0] b_x;

    // One adder serves both directions; compare flags come from the difference.
    always_comb
    begin
        a_x = {a[RW-1], a};
        b_x = {b[RW-1], b};
        sum = sub ? (a_x - b_x) : (a_x + b_x);
        eq  = (sum == '0);
        gt  = !sum[RW] && !eq;
    end

    // Saturate the result into the stored delay range.
    always_comb
    begin
        if ($signed(sum) > SAT_HI)
        begin
            sat = SAT_HI[DW-1:0];
        end
        else if ($signed(sum) < SAT_LO)
        begin
            sat = SAT_LO[DW-1:0];
        end
        else
        begin
            sat = sum[DW-1:0];
        end
    end
endmodule
`default_nettype wire

@@ hdl/dlts_table.sv @@
// Task table memory: one write port and one registered read port.
`default_nettype none
module dlts_table #(
    parameter int DEPTH = dlts_pkg::MAX_TASKS_DEF,
    parameter int AW    = $clog2(dlts_pkg::MAX_TASKS_DEF)
) (
    input  wire logic            clk,
    input  wire logic [AW-1:0]   rd_addr,
    output dlts_pkg::entry_t     rd_data,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  dlts_pkg::entry_t     wr_data
);
    dlts_pkg::entry_t mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered: data follows the address in the next cycle.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

@@ sim/tb_delta_list_task_scheduler.sv @@
// Testbench for the delta-list task scheduler: directed table plus random requests.
`timescale 1ns / 1ps
module tb_delta_list_task_scheduler;

    localparam int TASKS     = 32;
    localparam int D_MIN     = -131072;
    localparam int D_MAX     = 131071;
    localparam int CYCLE_CAP = 1500000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    dlts_pkg::req_word_t req;
    logic rsp_valid;
    logic rsp_ready;
    dlts_pkg::rsp_word_t rsp;

    delta_list_task_scheduler #(.MAX_TASKS(TASKS)) dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    // Shadow copy of the task table.
    logic [7:0]  sh_handle [TASKS+1];
    int          sh_delta  [TASKS+1];
    logic [15:0] sh_period [TASKS+1];
    logic [15:0] sh_ident  [TASKS+1];
    int          sh_count;
    logic [15:0] sh_next_id;

    dlts_pkg::rsp_word_t due_words[$];
    int        error_count;
    int        cycle_count;
    logic      stim_done;

    always #2 clk = ~clk;

    // Stop the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic int sat18(input int v);
        if (v < D_MIN) return D_MIN;
        if (v > D_MAX) return D_MAX;
        return v;
    endfunction

    function automatic void move_row(input int dst, input int src);
        sh_handle[dst] = sh_handle[src];
        sh_delta[dst]  = sh_delta[src];
        sh_period[dst] = sh_period[src];
        sh_ident[dst]  = sh_ident[src];
    endfunction

    function automatic void drop_row(input int i);
        sh_count--;
        if (i < sh_count) sh_delta[i+1] = sat18(sh_delta[i+1] + sh_delta[i]);
        for (int k = i; k < sh_count; k++) move_row(k, k + 1);
    endfunction

    function automatic bit sorts_later(input int rem, input logic [15:0] per, input int k);
        return rem > sh_delta[k] || (rem == sh_delta[k] && per <= sh_period[k]);
    endfunction

    function automatic dlts_pkg::rsp_word_t make_word(input dlts_pkg::status_t st,
                                                      input logic [15:0] id,
                                                      input logic rv, input logic [7:0] rh);
        dlts_pkg::rsp_word_t w;
        w.status = st; w.assigned_id = id; w.run_valid = rv; w.run_handle = rh;
        w.last = 1'b1;
        return w;
    endfunction

    // Apply one request to the shadow table and queue the words it produces.
    function automatic void schedule_request(input dlts_pkg::req_word_t r);
        int i;
        int rem;
        int n;
        logic [7:0]  h;
        logic [15:0] p;
        logic [15:0] id;
        dlts_pkg::rsp_word_t w;
        n = 0;
        case (dlts_pkg::req_kind_t'(r.req_type))
            dlts_pkg::REQ_TICK:
            begin
                if (sh_count > 0 && sh_delta[0] > D_MIN) sh_delta[0]--;
                due_words.push_back(make_word(dlts_pkg::ST_OK, 16'd0, 1'b0, 8'd0));
            end
            dlts_pkg::REQ_ADD:
            begin
                if (sh_count >= TASKS)
                    due_words.push_back(make_word(dlts_pkg::ST_FULL, 16'd0, 1'b0, 8'd0));
                else if (r.task_handle == 8'd0)
                    due_words.push_back(make_word(dlts_pkg::ST_NO_HANDLE, 16'd0, 1'b0,
                                                  8'd0));
                else
                begin
                    rem = int'(r.first_delay);
                    i = 0;
                    while (i < sh_count && sorts_later(rem, r.repeat_period, i))
                    begin
                        rem -= sh_delta[i];
                        i++;
                    end
                    if (i < sh_count)
                    begin
                        sh_delta[i] = sat18(sh_delta[i] - rem);
                        for (int j = sh_count; j > i; j--) move_row(j, j - 1);
                    end
                    sh_handle[i] = r.task_handle;
                    sh_delta[i]  = sat18(rem);
                    sh_period[i] = r.repeat_period;
                    sh_ident[i]  = sh_next_id;
                    sh_count++;
                    due_words.push_back(make_word(dlts_pkg::ST_OK, sh_next_id, 1'b0, 8'd0));
                    sh_next_id++;
                end
            end
            dlts_pkg::REQ_DEL:
            begin
                i = 0;
                while (i < sh_count && sh_ident[i] != r.target_id) i++;
                if (i >= sh_count)
                    due_words.push_back(make_word(dlts_pkg::ST_NOT_FOUND, 16'd0, 1'b0,
                                                  8'd0));
                else
                begin
                    drop_row(i);
                    due_words.push_back(make_word(dlts_pkg::ST_OK, 16'd0, 1'b0, 8'd0));
                end
            end
            default:
            begin
                while (n < dlts_pkg::DISP_CAP && sh_count > 0 && sh_delta[0] <= 0)
                begin
                    h = sh_handle[0]; p = sh_period[0]; id = sh_ident[0];
                    if (p != 16'd0)
                    begin
                        rem = int'(p);
                        i = 1;
                        while (i < sh_count && sorts_later(rem, p, i))
                        begin
                            rem -= sh_delta[i];
                            move_row(i - 1, i);
                            i++;
                        end
                        sh_handle[i-1] = h; sh_delta[i-1] = sat18(rem);
                        sh_period[i-1] = p; sh_ident[i-1] = id;
                        if (i < sh_count) sh_delta[i] = sat18(sh_delta[i] - rem);
                    end
                    else
                        drop_row(0);
                    w = make_word(dlts_pkg::ST_OK, 16'd0, 1'b1, h);
                    w.last = 1'b0;
                    due_words.push_back(w);
                    n++;
                end
                if (n == 0)
                    due_words.push_back(make_word(dlts_pkg::ST_OK, 16'd0, 1'b0, 8'd0));
                else
                    due_words[$].last = 1'b1;
            end
        endcase
    endfunction

    // Check each accepted result word and draw the receiver's stall.
    int stall_left;
    always @(posedge clk)
    begin
        dlts_pkg::rsp_word_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (due_words.size() == 0)
                    report("unexpected word", 1, 0);
                else
                begin
                    want = due_words.pop_front();
                    if (rsp.status != want.status)
                        report("status", rsp.status, want.status);
                    if (rsp.assigned_id != want.assigned_id)
                        report("assigned_id", rsp.assigned_id, want.assigned_id);
                    if (rsp.run_valid != want.run_valid)
                        report("run_valid", rsp.run_valid, want.run_valid);
                    if (rsp.run_handle != want.run_handle)
                        report("run_handle", rsp.run_handle, want.run_handle);
                    if (rsp.last != want.last)
                        report("last", rsp.last, want.last);
                end
            end
            if (rsp_ready && !rsp_valid)
                ;
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                rsp_ready <= 1'b0;
            end
            else if (rsp_valid && rsp_ready)
            begin
                stall_left <= stim_done || ($urandom_range(0, 3) == 0) ? 0
                              : $urandom_range(0, 10);
                rsp_ready <= 1'b1;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // Present one request word, hold it until accepted. Valid stays high after
    // the accepting edge; an idle gap or a drain lowers it.
    task automatic send_request(input dlts_pkg::req_word_t r, input bit quiet);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (!req_ready);
        schedule_request(r);
    endtask

    function automatic dlts_pkg::req_word_t build(input dlts_pkg::req_kind_t k,
                                                  input logic [7:0] h,
                                                  input logic [15:0] d,
                                                  input logic [15:0] p,
                                                  input logic [15:0] t);
        dlts_pkg::req_word_t r;
        r.req_type = k; r.task_handle = h; r.first_delay = d;
        r.repeat_period = p; r.target_id = t;
        return r;
    endfunction

    // Directed table; hard marks rows whose result is typed in.
    typedef struct {
        dlts_pkg::req_word_t r;
        bit                  hard;
        dlts_pkg::rsp_word_t want;
    } step_row_t;

    step_row_t steps[$];
    int        live_ids[$];

    // Lower valid and wait until every expected word has come.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (due_words.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        int kind;
        dlts_pkg::req_word_t r;
        dlts_pkg::rsp_word_t got;
        clk = 1'b0; rst_n = 1'b0; req_valid = 1'b0; rsp_ready = 1'b0;
        req = '0; error_count = 0; cycle_count = 0; stall_left = 0; stim_done = 1'b0;
        for (int k = 0; k <= TASKS; k++)
        begin
            sh_handle[k] = 0; sh_delta[k] = 0; sh_period[k] = 0; sh_ident[k] = 0;
        end
        sh_count = 0; sh_next_id = 16'd1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: empty-table cases, zero handle, extremes and ties.
        steps.push_back('{build(dlts_pkg::REQ_DISP, 8'd0, 16'd0, 16'd0, 16'd0), 1,
                          make_word(dlts_pkg::ST_OK, 16'd0, 1'b0, 8'd0)});
        steps.push_back('{build(dlts_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0, 16'd0), 1,
                          make_word(dlts_pkg::ST_OK, 16'd0, 1'b0, 8'd0)});
        steps.push_back('{build(dlts_pkg::REQ_DEL, 8'd0, 16'd0, 16'd0, 16'd1), 1,
                          make_word(dlts_pkg::ST_NOT_FOUND, 16'd0, 1'b0, 8'd0)});
        steps.push_back('{build(dlts_pkg::REQ_ADD, 8'd0, 16'd5, 16'd5, 16'd0), 1,
                          make_word(dlts_pkg::ST_NO_HANDLE, 16'd0, 1'b0, 8'd0)});
        steps.push_back('{build(dlts_pkg::REQ_ADD, 8'd255, 16'd0, 16'd0, 16'd0), 1,
                          make_word(dlts_pkg::ST_OK, 16'd1, 1'b0, 8'd0)});
        steps.push_back('{build(dlts_pkg::REQ_ADD, 8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                          0, '0});
        steps.push_back('{build(dlts_pkg::REQ_ADD, 8'd2, 16'd3, 16'd7, 16'd0), 0, '0});
        steps.push_back('{build(dlts_pkg::REQ_ADD, 8'd3, 16'd3, 16'd2, 16'd0), 0, '0});
        steps.push_back('{build(dlts_pkg::REQ_ADD, 8'd4, 16'd3, 16'd7, 16'd0), 0, '0});
        steps.push_back('{build(dlts_pkg::REQ_DISP, 8'd0, 16'd0, 16'd0, 16'd0), 0, '0});
        for (int k = 0; k < 4; k++)
            steps.push_back('{build(dlts_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0, 16'd0), 0,
                              '0});
        steps.push_back('{build(dlts_pkg::REQ_DISP, 8'd0, 16'd0, 16'd0, 16'd0), 0, '0});
        steps.push_back('{build(dlts_pkg::REQ_DEL, 8'd0, 16'd0, 16'd0, 16'd3), 0, '0});
        steps.push_back('{build(dlts_pkg::REQ_DEL, 8'd0, 16'd0, 16'd0, 16'd2), 0, '0});
        steps.push_back('{build(dlts_pkg::REQ_DISP, 8'd0, 16'd0, 16'd0, 16'd0), 0, '0});
        foreach (steps[s])
        begin
            if (steps[s].hard)
            begin
                send_request(steps[s].r, 1'b0);
                got = due_words[$];
                if (got != steps[s].want)
                    report("directed row", s, -1);
            end
            else
                send_request(steps[s].r, 1'b0);
        end

        // Fill the table to hit the full case, then clear its due tasks by dispatches.
        wait_drained();
        for (int k = 0; k < TASKS + 2; k++)
            send_request(build(dlts_pkg::REQ_ADD, 8'($urandom_range(1, 255)), 16'd0,
                               16'd0, 16'd0), k > TASKS - 3);
        send_request(build(dlts_pkg::REQ_DISP, 8'd0, 16'd0, 16'd0, 16'd0), 1'b0);
        send_request(build(dlts_pkg::REQ_DISP, 8'd0, 16'd0, 16'd0, 16'd0), 1'b0);
        wait_drained();

        // Random requests: adds, ticks, dispatches and deletes, mostly with small delays.
        for (int n = 0; n < 260; n++)
        begin
            kind = $urandom_range(0, 99);
            r = '0;
            r.task_handle   = 8'($urandom);
            r.target_id     = 16'($urandom);
            if ($urandom_range(0, 7) == 0)
            begin
                r.first_delay = 16'($urandom); r.repeat_period = 16'($urandom);
            end
            else
            begin
                r.first_delay   = 16'($urandom_range(0, 6));
                r.repeat_period = ($urandom_range(0, 2) == 0) ? 16'd0
                                  : 16'($urandom_range(1, 8));
            end
            if (kind < 35)
            begin
                r.req_type = dlts_pkg::REQ_ADD;
                if ($urandom_range(0, 15) == 0) r.task_handle = 8'd0;
            end
            else if (kind < 65)
                r.req_type = dlts_pkg::REQ_TICK;
            else if (kind < 85)
                r.req_type = dlts_pkg::REQ_DISP;
            else
            begin
                r.req_type = dlts_pkg::REQ_DEL;
                if (sh_count > 0 && $urandom_range(0, 3) != 0)
                    r.target_id = sh_ident[$urandom_range(0, sh_count - 1)];
            end
            send_request(r, n > 140 && n < 170);
            if (n == 200) wait_drained();
        end

        stim_done <= 1'b1;
        wait_drained();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ files.f @@
hdl/dlts_pkg.sv
hdl/dlts_alu.sv
hdl/dlts_table.sv
hdl/delta_list_task_scheduler.sv
sim/tb_delta_list_task_scheduler.sv
